/* rtl/two_pkg.sv */
// ----------------------------------------------------------------------------
// two_pkg: shared constants and helpers for tracking wheel odometry
// CORDIC step count, arctangent table, fixed point constants and saturation.
// ----------------------------------------------------------------------------
package two_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = 5;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;
  localparam logic [15:0] CENTIDEG_TURN = 16'd36000;

  // ((36000 - h) * 65536 + 18000) / 36000 == ((36000 - h) * 2048 + 562) / 1125,
  // the division done as a multiply by ceil(2^38 / 1125), exact below 2^27
  localparam logic [26:0] ANG_BIAS = 27'd562;
  localparam logic [27:0] ANG_RECIP = 28'd244335918;
  localparam int ANG_SHIFT = 38;

  localparam logic [1:0] REG_DIST_PER_DEG = 2'd0;
  localparam logic [1:0] REG_FWD_OFFSET = 2'd1;
  localparam logic [1:0] REG_SIDE_OFFSET = 2'd2;

  typedef logic signed [67:0] wide_t;

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > wide_t'(32'sh7fffffff)) r = 32'sh7fffffff;
    else if (v < wide_t'(-33'sh80000000)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/tracking_wheel_odometry.sv */
// ----------------------------------------------------------------------------
// tracking_wheel_odometry: arc based pose integration from two tracking wheels
// Integrates x,y in Q16.16 inches from wheel counts and an IMU heading.
// ----------------------------------------------------------------------------
// One tick is worked on at a time and in_ready is low meanwhile. The first
// tick after reset only latches the counts and heading. A tick with no heading
// change makes one 16-step cordic pass, and a tick with a turn makes two and
// also runs the 64-step bit-serial divider for the sinc factor; the heading
// conversion and all products share one 33x33 multiplier. A result waits in the
// output register while the next tick is taken in; a tick that finishes while the
// previous beat still waits holds until that beat has gone.
module tracking_wheel_odometry (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  forward_count,
  input  logic signed [31:0]  sideways_count,
  input  logic [15:0]         heading_centideg,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic [15:0]         heading_angle,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import two_pkg::*;

  typedef enum logic [4:0] {
    IDLE, ANG_MUL, MUL_DF, MUL_DS, SAT_DS, BRANCH, SIN_HALF, MUL_MAGS,
    DIV_START, DIV_F, LY_A, LY_B, LY_C, LX_B, LX_C, MID_START, ROT,
    GX_A, GX_B, GY_A, GY_B, GY_C, ACC_Y, FINISH
  } state_t;

  state_t state;

  logic [15:0]        dist_per_deg;
  logic signed [15:0] fwd_offset, side_offset;

  logic [31:0]        last_forward, last_sideways;
  logic [15:0]        last_angle;
  logic signed [31:0] acc_x, acc_y;
  logic               primed;

  logic [31:0]        fc, sc;
  logic [15:0]        ang;
  logic signed [31:0] df, ds, lx, ly;
  logic [31:0]        f;
  logic signed [35:0] term;
  logic signed [65:0] sum, prod;
  logic signed [37:0] gx, gy;

  logic signed [32:0] op_a, op_b;

  logic               cordic_start, cordic_busy, cordic_done;
  logic [31:0]        cordic_turns;
  logic signed [32:0] cos_val, sin_val;

  logic               div_start, div_busy, div_done;
  logic [63:0]        div_dividend, div_quotient;
  logic [31:0]        div_divisor;

  logic [15:0]        h_red;
  logic [26:0]        ang_num;
  logic [31:0]        fdiff, sdiff;
  logic signed [15:0] dth;
  logic [15:0]        mag_d;
  logic signed [32:0] mag_s;
  logic [15:0]        mid;

  assign h_red = (heading_centideg >= CENTIDEG_TURN) ?
                 heading_centideg - CENTIDEG_TURN : heading_centideg;
  assign ang_num = {16'(CENTIDEG_TURN - h_red), 11'b0} + ANG_BIAS;
  assign fdiff = fc - last_forward;
  assign sdiff = sc - last_sideways;
  assign dth = signed'(ang - last_angle);
  assign mag_d = dth[15] ? 16'(-dth) : dth;
  assign mag_s = sin_val[32] ? 33'(-sin_val) : sin_val;
  assign mid = ang - 16'(dth >>> 1);

  assign in_ready = (state == IDLE);

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      IDLE: begin
        op_a = signed'({6'b0, ang_num});
        op_b = signed'({5'b0, ANG_RECIP});
      end
      MUL_DF: begin
        op_a = signed'({fdiff[31], fdiff});
        op_b = signed'({17'b0, dist_per_deg});
      end
      MUL_DS: begin
        op_a = signed'({sdiff[31], sdiff});
        op_b = signed'({17'b0, dist_per_deg});
      end
      MUL_MAGS: begin
        op_a = mag_s;
        op_b = signed'({1'b0, INV_PI_Q32});
      end
      LY_A: begin
        op_a = 33'(df);
        op_b = signed'({1'b0, f});
      end
      LY_B: begin
        op_a = sin_val;
        op_b = 33'(fwd_offset);
      end
      LY_C: begin
        op_a = 33'(ds);
        op_b = signed'({1'b0, f});
      end
      LX_B: begin
        op_a = sin_val;
        op_b = 33'(side_offset);
      end
      GX_A: begin
        op_a = 33'(ly);
        op_b = cos_val;
      end
      GX_B: begin
        op_a = 33'(lx);
        op_b = sin_val;
      end
      GY_A: begin
        op_a = 33'(ly);
        op_b = sin_val;
      end
      GY_B: begin
        op_a = 33'(lx);
        op_b = cos_val;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  assign cordic_start = (state == BRANCH && dth != 16'sd0) || (state == MID_START);
  assign cordic_turns = (state == MID_START) ? {mid, 16'b0} : {dth[15], dth, 15'b0};

  assign div_start = (state == DIV_START);
  assign div_dividend = prod[63:0];
  assign div_divisor = {mag_d, 16'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_deg <= 16'd50328;
      fwd_offset <= 16'sd832;
      side_offset <= 16'sd512;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIST_PER_DEG: dist_per_deg <= cfg_data;
        REG_FWD_OFFSET:   fwd_offset <= signed'(cfg_data);
        REG_SIDE_OFFSET:  side_offset <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      primed <= 1'b0;
      last_forward <= '0;
      last_sideways <= '0;
      last_angle <= '0;
      acc_x <= '0;
      acc_y <= '0;
    end else begin
      if (out_valid && out_ready && state != FINISH) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_valid) begin
            fc <= forward_count;
            sc <= sideways_count;
            state <= ANG_MUL;
          end
        end
        ANG_MUL: begin
          ang <= prod[ANG_SHIFT +: 16];
          state <= primed ? MUL_DF : FINISH;
        end
        MUL_DF: state <= MUL_DS;
        MUL_DS: begin
          df <= sat32(wide_t'(prod >>> 4));
          state <= SAT_DS;
        end
        SAT_DS: begin
          ds <= sat32(wide_t'(prod >>> 4));
          state <= BRANCH;
        end
        BRANCH: begin
          if (dth == 16'sd0) begin
            // no turn: straight local motion
            lx <= ds;
            ly <= df;
            state <= MID_START;
          end else begin
            state <= SIN_HALF;
          end
        end
        SIN_HALF: if (cordic_done) state <= MUL_MAGS;
        MUL_MAGS: state <= DIV_START;
        DIV_START: state <= DIV_F;
        DIV_F: begin
          if (div_done) begin
            f <= div_quotient[31:0];
            state <= LY_A;
          end
        end
        LY_A: state <= LY_B;
        LY_B: begin
          term <= 36'(prod >>> 30);
          state <= LY_C;
        end
        LY_C: begin
          ly <= sat32(wide_t'(term) + wide_t'(prod >>> 21));
          state <= LX_B;
        end
        LX_B: begin
          term <= 36'(prod >>> 30);
          state <= LX_C;
        end
        LX_C: begin
          lx <= sat32(wide_t'(term) + wide_t'(prod >>> 21));
          state <= MID_START;
        end
        MID_START: state <= ROT;
        ROT: if (cordic_done) state <= GX_A;
        GX_A: state <= GX_B;
        GX_B: begin
          sum <= prod;
          state <= GY_A;
        end
        GY_A: begin
          gx <= 38'((wide_t'(sum) - wide_t'(prod)) >>> 30);
          state <= GY_B;
        end
        GY_B: begin
          sum <= prod;
          acc_x <= sat32(wide_t'(acc_x) + wide_t'(gx));
          state <= GY_C;
        end
        GY_C: begin
          gy <= 38'((wide_t'(sum) + wide_t'(prod)) >>> 30);
          state <= ACC_Y;
        end
        ACC_Y: begin
          acc_y <= sat32(wide_t'(acc_y) + wide_t'(gy));
          state <= FINISH;
        end
        FINISH: begin
          // hold until the previous result beat has gone
          if (!out_valid || out_ready) begin
            pos_x <= acc_x;
            pos_y <= acc_y;
            heading_angle <= ang;
            out_valid <= 1'b1;
            last_forward <= fc;
            last_sideways <= sc;
            last_angle <= ang;
            primed <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  two_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .turns   (cordic_turns),
    .busy    (cordic_busy),
    .done    (cordic_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  two_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  a_cordic_free: assert property (@(posedge clk) disable iff (rst)
    cordic_start |-> !cordic_busy)
    else $error("cordic started while busy");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second tick taken while one is in work");

  a_primed_holds: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed flag dropped");

endmodule

/* rtl/two_cordic.sv */
// ----------------------------------------------------------------------------
// two_cordic: iterative rotation-mode cordic
// One micro-rotation per cycle; returns cos and sin in Q3.30 of a 2^-32 turn.
// ----------------------------------------------------------------------------
module two_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        turns,
  output logic               busy,
  output logic               done,
  output logic signed [32:0] cos_val,
  output logic signed [32:0] sin_val
);
  import two_pkg::*;

  localparam logic signed [33:0] QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] HALF = 34'sd2147483648;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic signed [33:0] x, y, z;
  logic               flip;
  logic [STEP_W-1:0]  step;
  logic signed [33:0] z_in, xs, ys, at;

  assign z_in = {{2{turns[31]}}, turns};
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = signed'({2'b00, atan_turns(step)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // fold into the right half plane
        if (z_in > QUARTER) begin
          z <= z_in - HALF;
          flip <= 1'b1;
        end else if (z_in < -QUARTER) begin
          z <= z_in + HALF;
          flip <= 1'b1;
        end else begin
          z <= z_in;
          flip <= 1'b0;
        end
        x <= CORDIC_GAIN_Q30;
        y <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_val = flip ? 33'(-x) : x[32:0];
  assign sin_val = flip ? 33'(-y) : y[32:0];

endmodule

/* rtl/two_divider.sv */
// ----------------------------------------------------------------------------
// two_divider: radix-2 restoring divider
// 64-bit unsigned dividend by a nonzero 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module two_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quotient
);
  import two_pkg::*;

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  count;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quotient[63]};
  assign fits = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        dsr <= divisor;
        rem <= '0;
        count <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? 32'(trial - {1'b0, dsr}) : trial[31:0];
        quotient <= {quotient[62:0], fits};
        count <= count + 1'b1;
        if (count == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
